FILE: hw/rtl/radio_tuner_control_sequencer_unit_defines.svh
// assertion macros for the tuner control sequencer
// no dependencies; included by files that hold concurrent assertions
`ifndef RADIO_TUNER_CONTROL_SEQUENCER_UNIT_DEFINES_SVH
`define RADIO_TUNER_CONTROL_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RTCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RTCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rtcs_pkg.sv
// types, constants and helper functions of the tuner control sequencer
// no dependencies
package rtcs_pkg;

  typedef enum logic [2:0] {
    OP_FREQ   = 3'd0,
    OP_VOLUME = 3'd1,
    OP_MUTE   = 3'd2,
    OP_QUERY  = 3'd3,
    OP_SAMPLE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_BIT  = 2'd1,
    KIND_SIG  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    WAIT_NONE  = 3'd0,
    WAIT_100MS = 3'd1,
    WAIT_200MS = 3'd2,
    WAIT_10MS  = 3'd3,
    WAIT_1MS   = 3'd4
  } wait_e;

  // which result beat the controller asks for
  typedef enum logic [3:0] {
    RES_BIT,
    RES_ZERO,
    RES_C8,
    RES_C0,
    RES_UP,
    RES_DOWN,
    RES_F8,
    RES_SIG,
    RES_E8
  } res_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CODE,
    ST_BITS,
    ST_FZ,
    ST_FC8,
    ST_VCHK,
    ST_VM0,
    ST_VM1,
    ST_VSTEP,
    ST_VREL,
    ST_VU0,
    ST_VU1,
    ST_MU0,
    ST_MU1,
    ST_QRY,
    ST_SREP,
    ST_SE8
  } state_e;

  localparam logic [10:0] FreqMin    = 11'd1408;
  localparam logic [10:0] FreqMax    = 11'd1728;
  // x/5 as (x*3277)>>14, exact for x below 4096
  localparam logic [11:0] Div5Mul    = 12'd3277;
  localparam int          Div5Shift  = 14;
  localparam logic [15:0] CodeOfs    = 16'(32'h0F6C - 40 * 88);
  localparam logic [7:0]  TrailByte  = 8'hA0;
  localparam int          BitCount   = 24;
  localparam logic [7:0]  TunedByte  = 8'hFD;
  localparam logic [7:0]  ByteZero   = 8'h00;
  localparam logic [7:0]  ByteC8     = 8'hC8;
  localparam logic [7:0]  ByteC0     = 8'hC0;
  localparam logic [7:0]  ByteUp     = 8'h88;
  localparam logic [7:0]  ByteDown   = 8'h48;
  localparam logic [7:0]  ByteQuery  = 8'hF8;
  localparam logic [7:0]  ByteSample = 8'hE8;
  localparam int          VolDiv     = 6554;
  localparam int          MaxLevel   = 9;

  typedef struct packed {
    logic  load;
    logic  code_load;
    logic  commit;
    logic  clear_level;
    logic  emit;
    res_e  res;
    wait_e wait_c;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic       slot_free;
    logic       bit_end;
    logic       lvl_eq;
    logic       new_zero;
    logic       cur_eq;
    logic       cur_up;
    logic       old_zero;
    logic [3:0] level;
  } status_t;

  // raw volume to level by threshold compares, all independent
  function automatic logic [3:0] vol_level(input logic [15:0] v);
    logic [3:0] l;
    l = '0;
    for (int k = 1; k <= MaxLevel; k++) begin
      if ({1'b0, v} >= 17'(k * VolDiv)) l = 4'(k);
    end
    return l;
  endfunction

endpackage

FILE: hw/rtl/rtcs_in_if.sv
// input channel of the tuner control sequencer: valid/ready plus command fields
// no dependencies
interface rtcs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [10:0] frequency;
  logic [15:0] volume;
  logic [7:0]  sample;

  modport source (output valid, op, frequency, volume, sample, input ready);
  modport sink (input valid, op, frequency, volume, sample, output ready);
endinterface

FILE: hw/rtl/rtcs_out_if.sv
// output channel of the tuner control sequencer: valid/ready plus result fields
// no dependencies
interface rtcs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic       bit_value;
  logic       tuned;
  logic [2:0] wait_code;
  logic       last;

  modport source (output valid, kind, byte_value, bit_value, tuned, wait_code, last,
                  input ready);
  modport sink (input valid, kind, byte_value, bit_value, tuned, wait_code, last,
                output ready);
endinterface

FILE: hw/rtl/rtcs_ctrl.sv
// controller state machine of the tuner control sequencer
// depends on rtcs_pkg
module rtcs_ctrl
  import rtcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] in_op_i,
  output logic       in_ready_o,
  input  status_t    status_i,
  output cmd_t       cmd_o,
  output state_e     state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

  always_comb begin
    logic fire;
    fire       = status_i.slot_free;
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.res    = RES_ZERO;
    cmd_o.wait_c = WAIT_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_op_i)
            OP_FREQ:   state_d = ST_CODE;
            OP_VOLUME: state_d = ST_VCHK;
            OP_MUTE: begin
              cmd_o.clear_level = 1'b1;
              state_d = ST_MU0;
            end
            OP_QUERY:  state_d = ST_QRY;
            OP_SAMPLE: state_d = ST_SREP;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_CODE: begin
        cmd_o.code_load = 1'b1;
        state_d = ST_BITS;
      end
      ST_BITS: begin
        cmd_o.emit   = fire;
        cmd_o.res    = RES_BIT;
        cmd_o.wait_c = status_i.bit_end ? WAIT_1MS : WAIT_NONE;
        if (fire && status_i.bit_end) state_d = ST_FZ;
      end
      ST_FZ: begin
        cmd_o.emit = fire;
        if (fire) state_d = ST_FC8;
      end
      ST_FC8: begin
        cmd_o.emit = fire;
        cmd_o.res  = RES_C8;
        cmd_o.last = 1'b1;
        if (fire) state_d = ST_IDLE;
      end
      ST_VCHK: begin
        cmd_o.commit = 1'b1;
        if (status_i.lvl_eq) state_d = ST_IDLE;
        else if (status_i.new_zero) state_d = ST_VM0;
        else state_d = ST_VSTEP;
      end
      ST_VM0: begin
        cmd_o.emit = fire;
        if (fire) state_d = ST_VM1;
      end
      ST_VM1: begin
        cmd_o.emit = fire;
        cmd_o.res  = RES_C0;
        if (fire) state_d = ST_VSTEP;
      end
      ST_VSTEP: begin
        cmd_o.emit   = fire;
        cmd_o.res    = status_i.cur_up ? RES_UP : RES_DOWN;
        cmd_o.wait_c = WAIT_100MS;
        if (fire) state_d = ST_VREL;
      end
      ST_VREL: begin
        cmd_o.emit = fire;
        cmd_o.res  = RES_C8;
        cmd_o.last = status_i.cur_eq && !status_i.old_zero;
        if (fire) begin
          if (!status_i.cur_eq) state_d = ST_VSTEP;
          else if (status_i.old_zero) state_d = ST_VU0;
          else state_d = ST_IDLE;
        end
      end
      ST_VU0: begin
        cmd_o.emit = fire;
        if (fire) state_d = ST_VU1;
      end
      ST_VU1: begin
        cmd_o.emit = fire;
        cmd_o.res  = RES_C8;
        cmd_o.last = 1'b1;
        if (fire) state_d = ST_IDLE;
      end
      ST_MU0: begin
        cmd_o.emit = fire;
        if (fire) state_d = ST_MU1;
      end
      ST_MU1: begin
        cmd_o.emit = fire;
        cmd_o.res  = RES_C0;
        cmd_o.last = 1'b1;
        if (fire) state_d = ST_IDLE;
      end
      ST_QRY: begin
        cmd_o.emit   = fire;
        cmd_o.res    = RES_F8;
        cmd_o.wait_c = WAIT_200MS;
        cmd_o.last   = 1'b1;
        if (fire) state_d = ST_IDLE;
      end
      ST_SREP: begin
        // report beat, the 0xe8 write follows
        cmd_o.emit   = fire;
        cmd_o.res    = RES_SIG;
        cmd_o.wait_c = WAIT_10MS;
        if (fire) state_d = ST_SE8;
      end
      ST_SE8: begin
        cmd_o.emit = fire;
        cmd_o.res  = RES_E8;
        cmd_o.last = 1'b1;
        if (fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/rtcs_dp.sv
// datapath of the tuner control sequencer: code math, level tracking, output register
// depends on rtcs_pkg
module rtcs_dp
  import rtcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [10:0] in_frequency_i,
  input  logic [15:0] in_volume_i,
  input  logic [7:0]  in_sample_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_value_o,
  output logic        out_bit_value_o,
  output logic        out_tuned_o,
  output logic [2:0]  out_wait_code_o,
  output logic        out_last_o
);

  localparam int CntW = $clog2(BitCount);

  logic [10:0]          freq_q;
  logic [3:0]           newl_q;
  logic                 tuned_q;
  logic [3:0]           level_q;
  logic [3:0]           cur_q;
  logic                 old_zero_q;
  logic [BitCount-1:0]  shreg_q;
  logic [CntW-1:0]      cnt_q;

  logic                 out_valid_q;
  kind_e                kind_q;
  logic [7:0]           byte_q;
  logic                 bit_q;
  logic                 tuned_out_q;
  wait_e                wait_q;
  logic                 last_q;

  logic [10:0] freq_clamped;
  logic [11:0] dbl;
  logic [23:0] prod;
  logic [15:0] code;

  always_comb begin
    freq_clamped = in_frequency_i;
    if (freq_clamped < FreqMin) freq_clamped = FreqMin;
    if (freq_clamped > FreqMax) freq_clamped = FreqMax;
  end

  // f*2/5 by reciprocal multiply, from the registered frequency
  assign dbl  = {freq_q, 1'b0};
  assign prod = dbl * Div5Mul;
  assign code = 16'(prod[23:Div5Shift]) + CodeOfs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      freq_q  <= freq_clamped;
      newl_q  <= vol_level(in_volume_i);
      tuned_q <= (in_sample_i == TunedByte);
    end
    if (cmd_i.code_load) begin
      shreg_q <= {TrailByte, code};
    end else if (cmd_i.emit && cmd_i.res == RES_BIT) begin
      shreg_q <= {1'b0, shreg_q[BitCount-1:1]};
    end
    if (cmd_i.commit) begin
      cur_q      <= level_q;
      old_zero_q <= (level_q == 4'd0);
    end else if (cmd_i.emit && cmd_i.res == RES_UP) begin
      cur_q <= cur_q + 4'd1;
    end else if (cmd_i.emit && cmd_i.res == RES_DOWN) begin
      cur_q <= cur_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      cnt_q      <= '0;
    end else begin
      if (cmd_i.clear_level) level_q <= '0;
      else if (cmd_i.commit) level_q <= newl_q;
      if (cmd_i.code_load) cnt_q <= '0;
      else if (cmd_i.emit && cmd_i.res == RES_BIT) cnt_q <= cnt_q + CntW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      wait_q      <= cmd_i.wait_c;
      last_q      <= cmd_i.last;
      kind_q      <= KIND_BYTE;
      byte_q      <= ByteZero;
      bit_q       <= 1'b0;
      tuned_out_q <= 1'b0;
      case (cmd_i.res)
        RES_BIT: begin
          kind_q <= KIND_BIT;
          bit_q  <= shreg_q[0];
        end
        RES_ZERO: byte_q <= ByteZero;
        RES_C8:   byte_q <= ByteC8;
        RES_C0:   byte_q <= ByteC0;
        RES_UP:   byte_q <= ByteUp;
        RES_DOWN: byte_q <= ByteDown;
        RES_F8:   byte_q <= ByteQuery;
        RES_SIG: begin
          kind_q      <= KIND_SIG;
          tuned_out_q <= tuned_q;
        end
        RES_E8:   byte_q <= ByteSample;
        default:  byte_q <= ByteZero;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = kind_q;
  assign out_byte_value_o = byte_q;
  assign out_bit_value_o  = bit_q;
  assign out_tuned_o      = tuned_out_q;
  assign out_wait_code_o  = wait_q;
  assign out_last_o       = last_q;

  always_comb begin
    status_o.slot_free = !out_valid_q || out_ready_i;
    status_o.bit_end   = (cnt_q == CntW'(BitCount - 1));
    status_o.lvl_eq    = (newl_q == level_q);
    status_o.new_zero  = (newl_q == 4'd0);
    status_o.cur_eq    = (cur_q == newl_q);
    status_o.cur_up    = (cur_q < newl_q);
    status_o.old_zero  = old_zero_q;
    status_o.level     = level_q;
  end

endmodule

FILE: hw/rtl/radio_tuner_control_sequencer_unit.sv
// top level of the tuner control sequencer: controller plus datapath
// depends on rtcs_pkg, rtcs_in_if, rtcs_out_if, rtcs_ctrl, rtcs_dp and the defines header
//
//   channel  dir  beat contents
//   in_i     in   op, frequency, volume, sample (one command)
//   out_o    out  kind, byte_value, bit_value, tuned, wait_code, last (one result)
//
// one command at a time: in_i.ready is high only while the controller is idle
// set frequency: accept and code-load states, then 26 beats
// set volume: accept and check states, then 0 to 20 beats
// mute, query, sample: accept state, then 2, 1 and 2 beats
// beats leave through a single output register; a stalled sink holds the controller
// reset clears the controller, the output valid and the stored level (card muted)
`include "radio_tuner_control_sequencer_unit_defines.svh"

module radio_tuner_control_sequencer_unit
  import rtcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rtcs_in_if.sink    in_i,
  rtcs_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;
  state_e  state;

  // sequencing of each command
  rtcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  // arithmetic, level tracking and the output register
  rtcs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_frequency_i   (in_i.frequency),
    .in_volume_i      (in_i.volume),
    .in_sample_i      (in_i.sample),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_kind_o       (out_o.kind),
    .out_byte_value_o (out_o.byte_value),
    .out_bit_value_o  (out_o.bit_value),
    .out_tuned_o      (out_o.tuned),
    .out_wait_code_o  (out_o.wait_code),
    .out_last_o       (out_o.last)
  );

  // a beat is only produced when the output register can take it
  `RTCS_ASSERT_NOW(a_emit_slot, clk_i, rst_ni, cmd.emit, !out_o.valid || out_o.ready,
                   "beat emitted into an occupied output register")

  // the final beat of a command returns the controller to idle
  `RTCS_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, cmd.emit && cmd.last, state == ST_IDLE,
                    "controller busy after the final beat")

  // the stored level never leaves the range a 16-bit volume can reach
  `RTCS_ASSERT_NOW(a_level_range, clk_i, rst_ni, 1'b1, status.level <= 4'(MaxLevel),
                   "volume level out of range")

endmodule

FILE: bench/tb_radio_tuner_control_sequencer_unit.sv
// testbench for the tuner control sequencer: directed and random commands, with
// every result beat checked against a local model of the card protocol
// depends on rtcs_pkg, rtcs_in_if, rtcs_out_if and radio_tuner_control_sequencer_unit
`timescale 1ns / 1ps

module tb_radio_tuner_control_sequencer_unit;
  import rtcs_pkg::*;

  // spare opcodes, the block must swallow them without any beat
  localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

  // card protocol constants, kept local so the model does not lean on the rtl
  localparam int unsigned FREQ_BOTTOM  = 1408;
  localparam int unsigned FREQ_TOP     = 1728;
  localparam int unsigned FREQ_BASE    = 40 * 88;
  localparam int unsigned FREQ_OFFSET  = 32'h0F6C;
  localparam logic [7:0]  FREQ_TRAILER = 8'hA0;
  localparam int unsigned VOL_STEP     = 6554;
  localparam logic [7:0]  SIG_LOCK     = 8'hFD;
  localparam logic [7:0]  PORT_ZERO    = 8'h00;
  localparam logic [7:0]  PORT_IDLE    = 8'hC8;
  localparam logic [7:0]  PORT_MUTE    = 8'hC0;
  localparam logic [7:0]  PORT_VOL_UP  = 8'h88;
  localparam logic [7:0]  PORT_VOL_DN  = 8'h48;
  localparam logic [7:0]  PORT_QUERY   = 8'hF8;
  localparam logic [7:0]  PORT_SAMPLE  = 8'hE8;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    kind_e      kind;
    logic [7:0] byte_value;
    logic       bit_value;
    logic       tuned;
    wait_e      wait_code;
    logic       last;
  } tuner_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rtcs_in_if  cmd_if ();
  rtcs_out_if res_if ();

  radio_tuner_control_sequencer_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // model state and bookkeeping
  tuner_beat_t tuner_beats_q[$];   // beats the card should see, oldest first
  logic [3:0]  card_level;         // volume level the model believes is set
  int          send_gap_pct;       // chance per cycle that the command side idles
  int          recv_gap_pct;       // chance per cycle that the result side stalls
  int          mismatches;
  int          commands_sent;
  int          spare_sent;
  int          beats_checked;
  int          cycle_count;

  // 20 ns clock, high half then low half
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog, counts every cycle from the start
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycle_count,
               tuner_beats_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic tuner_beat_t make_beat(input kind_e k, input logic [7:0] b,
                                            input logic bv, input logic t,
                                            input wait_e w);
    tuner_beat_t r;
    r.kind       = k;
    r.byte_value = b;
    r.bit_value  = bv;
    r.tuned      = t;
    r.wait_code  = w;
    r.last       = 1'b0;
    return r;
  endfunction

  // works out the beats one accepted command causes and updates the level
  function automatic void sequence_command(input logic [2:0] op, input logic [10:0] freq,
                                           input logic [15:0] vol, input logic [7:0] smp);
    tuner_beat_t run[$];
    int unsigned f;
    int unsigned code;
    int unsigned new_level;
    int unsigned old_level;
    case (op)
      OP_FREQ: begin
        // clamp to the fm band, then the card's divider code
        f = freq;
        if (f < FREQ_BOTTOM) f = FREQ_BOTTOM;
        if (f > FREQ_TOP) f = FREQ_TOP;
        code = ((f * 2) / 5 - FREQ_BASE + FREQ_OFFSET) & 32'hFFFF;
        // 16 code bits then the trailer byte, lsb first
        for (int i = 0; i < 16; i++)
          run.push_back(make_beat(KIND_BIT, PORT_ZERO, code[i], 1'b0, WAIT_NONE));
        for (int i = 0; i < 8; i++)
          run.push_back(make_beat(KIND_BIT, PORT_ZERO, FREQ_TRAILER[i], 1'b0, WAIT_NONE));
        // settle time hangs off the final serial bit
        run[run.size() - 1].wait_code = WAIT_1MS;
        run.push_back(make_beat(KIND_BYTE, PORT_ZERO, 1'b0, 1'b0, WAIT_NONE));
        run.push_back(make_beat(KIND_BYTE, PORT_IDLE, 1'b0, 1'b0, WAIT_NONE));
      end
      OP_VOLUME: begin
        new_level = vol / VOL_STEP;
        old_level = card_level;
        if (new_level == old_level) return;
        // going to silence mutes first
        if (new_level == 0) begin
          run.push_back(make_beat(KIND_BYTE, PORT_ZERO, 1'b0, 1'b0, WAIT_NONE));
          run.push_back(make_beat(KIND_BYTE, PORT_MUTE, 1'b0, 1'b0, WAIT_NONE));
        end
        // one pulse pair per level step
        for (int unsigned i = 0; i < ((new_level > old_level) ? new_level - old_level
                                                              : old_level - new_level); i++) begin
          run.push_back(make_beat(KIND_BYTE, (new_level > old_level) ? PORT_VOL_UP : PORT_VOL_DN,
                                  1'b0, 1'b0, WAIT_100MS));
          run.push_back(make_beat(KIND_BYTE, PORT_IDLE, 1'b0, 1'b0, WAIT_NONE));
        end
        // leaving silence unmutes afterwards
        if (old_level == 0) begin
          run.push_back(make_beat(KIND_BYTE, PORT_ZERO, 1'b0, 1'b0, WAIT_NONE));
          run.push_back(make_beat(KIND_BYTE, PORT_IDLE, 1'b0, 1'b0, WAIT_NONE));
        end
        card_level = 4'(new_level);
      end
      OP_MUTE: begin
        run.push_back(make_beat(KIND_BYTE, PORT_ZERO, 1'b0, 1'b0, WAIT_NONE));
        run.push_back(make_beat(KIND_BYTE, PORT_MUTE, 1'b0, 1'b0, WAIT_NONE));
        card_level = '0;
      end
      OP_QUERY: begin
        run.push_back(make_beat(KIND_BYTE, PORT_QUERY, 1'b0, 1'b0, WAIT_200MS));
      end
      OP_SAMPLE: begin
        run.push_back(make_beat(KIND_SIG, PORT_ZERO, 1'b0, smp == SIG_LOCK, WAIT_10MS));
        run.push_back(make_beat(KIND_BYTE, PORT_SAMPLE, 1'b0, 1'b0, WAIT_NONE));
      end
      default: begin
        // spare opcode, nothing happens
      end
    endcase
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) tuner_beats_q.push_back(run[i]);
  endfunction

  // one command beat; valid stays up after the handshake so back-to-back
  // commands never see valid dropped and raised in the same step
  task automatic send_command(input logic [2:0] op, input logic [10:0] freq,
                              input logic [15:0] vol, input logic [7:0] smp);
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.op        <= op;
    cmd_if.frequency <= freq;
    cmd_if.volume    <= vol;
    cmd_if.sample    <= smp;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sequence_command(op, freq, vol, smp);
    commands_sent++;
    if (op >= OP_SPARE_FIRST) spare_sent++;
  endtask

  // result side: random stalls, each accepted beat checked against the oldest owed one
  initial begin
    tuner_beat_t want;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (tuner_beats_q.size() == 0) begin
          $error("beat with nothing owed: kind %0d byte %h bit %0d", res_if.kind,
                 res_if.byte_value, res_if.bit_value);
          mismatches++;
        end else begin
          want = tuner_beats_q.pop_front();
          beats_checked++;
          if (res_if.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, res_if.kind);
            mismatches++;
          end
          if (res_if.byte_value !== want.byte_value) begin
            $error("byte_value: expected %h, got %h", want.byte_value, res_if.byte_value);
            mismatches++;
          end
          if (res_if.bit_value !== want.bit_value) begin
            $error("bit_value: expected %0d, got %0d", want.bit_value, res_if.bit_value);
            mismatches++;
          end
          if (res_if.tuned !== want.tuned) begin
            $error("tuned: expected %0d, got %0d", want.tuned, res_if.tuned);
            mismatches++;
          end
          if (res_if.wait_code !== want.wait_code) begin
            $error("wait_code: expected %0d, got %0d", want.wait_code, res_if.wait_code);
            mismatches++;
          end
          if (res_if.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_if.last);
            mismatches++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // band edges, both clamps and one mid-band channel
  task automatic test_frequency_edges();
    send_command(OP_FREQ, 11'd1408, 16'h0000, 8'h00);
    send_command(OP_FREQ, 11'd1728, 16'hFFFF, 8'hFF);
    send_command(OP_FREQ, 11'd0, 16'h0000, 8'h00);
    send_command(OP_FREQ, 11'h7FF, 16'h0000, 8'h00);
    send_command(OP_FREQ, 11'd1600, 16'h0000, 8'h00);
  endtask

  // no-change request, threshold edge, full swing up and down, mute on zero,
  // unmute when starting from zero
  task automatic test_volume_steps();
    send_command(OP_VOLUME, 11'd0, 16'(VOL_STEP - 1), 8'h00);
    send_command(OP_VOLUME, 11'd0, 16'(VOL_STEP), 8'h00);
    send_command(OP_VOLUME, 11'd0, 16'hFFFF, 8'h00);
    send_command(OP_VOLUME, 11'd0, 16'(2 * VOL_STEP), 8'h00);
    send_command(OP_VOLUME, 11'd0, 16'h0000, 8'h00);
    send_command(OP_VOLUME, 11'd0, 16'hFFFF, 8'h00);
  endtask

  // mute from full level, then a volume change out of the muted state,
  // then the signal query with a locked and two unlocked samples
  task automatic test_mute_and_signal();
    send_command(OP_MUTE, 11'd0, 16'h0000, 8'h00);
    send_command(OP_VOLUME, 11'd0, 16'd30000, 8'h00);
    send_command(OP_QUERY, 11'd0, 16'h0000, 8'h00);
    send_command(OP_SAMPLE, 11'd0, 16'h0000, SIG_LOCK);
    send_command(OP_QUERY, 11'd0, 16'h0000, 8'h00);
    send_command(OP_SAMPLE, 11'd0, 16'h0000, 8'h00);
    send_command(OP_SAMPLE, 11'd0, 16'h0000, 8'hFF);
  endtask

  // spare opcodes must be taken and dropped
  task automatic test_spare_opcodes();
    for (logic [3:0] op = 4'(OP_SPARE_FIRST); op <= 4'(OP_SPARE_LAST); op++)
      send_command(3'(op), 11'h7FF, 16'hFFFF, 8'hFF);
  endtask

  // mixed traffic; query is mostly followed by its sample, the rest is loose
  task automatic test_random_traffic(input int n_cmds);
    int          counted;
    int          pick;
    logic [10:0] f;
    logic [15:0] v;
    logic [7:0]  s;
    counted = 0;
    while (counted < n_cmds) begin
      pick = $urandom_range(99);
      f = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(FREQ_TOP, FREQ_BOTTOM));
      // about a third of volumes sit right at a level threshold
      v = ($urandom_range(2) == 0) ? 16'($urandom_range(9) * VOL_STEP - $urandom_range(1))
                                   : 16'($urandom);
      s = ($urandom_range(2) == 0) ? SIG_LOCK : 8'($urandom);
      if (pick < 25) begin
        send_command(OP_FREQ, f, v, s);
        counted++;
      end else if (pick < 55) begin
        send_command(OP_VOLUME, f, v, s);
        counted++;
      end else if (pick < 65) begin
        send_command(OP_MUTE, f, v, s);
        counted++;
      end else if (pick < 85) begin
        send_command(OP_QUERY, f, v, s);
        send_command(OP_SAMPLE, f, v, s);
        counted += 2;
      end else if (pick < 90) begin
        send_command(OP_SAMPLE, f, v, s);
        counted++;
      end else if (pick < 95) begin
        send_command(OP_QUERY, f, v, s);
        counted++;
      end else begin
        send_command(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), f, v, s);
        counted++;
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.op        = OP_FREQ;
    cmd_if.frequency = '0;
    cmd_if.volume    = '0;
    cmd_if.sample    = '0;
    card_level       = '0;
    mismatches       = 0;
    commands_sent    = 0;
    spare_sent       = 0;
    beats_checked    = 0;
    cycle_count      = 0;
    send_gap_pct     = 6;
    recv_gap_pct     = 75;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part and first random pass: slow result side
    test_frequency_edges();
    test_volume_steps();
    test_mute_and_signal();
    test_spare_opcodes();
    test_random_traffic(36);

    // slow command side
    send_gap_pct = 75;
    recv_gap_pct = 6;
    test_random_traffic(36);

    // both sides at full rate
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traffic(37);
    cmd_if.valid <= 1'b0;

    // drain, then give the block time to show any stray beat
    while (tuner_beats_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d commands (%0d spare opcodes) and checked %0d result beats",
             commands_sent, spare_sent, beats_checked);
    $display("pacing covered slow sink, slow source and full rate; final level %0d",
             card_level);
    if (mismatches == 0 && tuner_beats_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
